/* src/tkt_pkg.sv */
// Shared types and constants for the top-K largest tracker.
// Used by tkt_cell and top_k_largest_tracker_unit; depends on nothing.
package tkt_pkg;

  localparam int DATA_W = 32;
  localparam int KEEP_W = 5;
  localparam int ADDR_W = 2;
  localparam int APB_W  = 32;

  typedef logic signed [DATA_W-1:0] tkt_data_t;

  // Operation applied to every cell of the chain at once.
  typedef struct packed {
    logic ins;   // insert a value in sorted position, shift larger ones up
    logic repl;  // drop the minimum, shift smaller ones down, place the value
    logic rot;   // rotate the filled entries down by one for read-out
  } tkt_ctl_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_DUMP = 1'b1;

endpackage

/* src/top_k_largest_tracker_unit.sv */
// Top level of the top-K largest tracker: control, configuration port
// and the chain of tkt_cell instances. Depends on tkt_pkg and tkt_cell.
//
// Usage:
//   Input channel: an item is accepted at a rising edge with start high
//   and busy low. operation selects push (value offered) or dump.
//   A push completes at the edge that accepts it: every cell
//   compares the value against its own entry and the whole chain
//   inserts or replaces together, so pushes may follow back to back.
//   A push gives no result. A dump raises busy and reads the held
//   values out by rotating the filled cells down by one per cycle,
//   taking cell 0 each time. Results follow one per cycle, and busy
//   drops at the edge that registers the last result. For n held values,
//   after n rotations the chain is back in its original order.
//   An empty dump gives one result (valid_res low, last high) in the
//   cycle after acceptance and does not raise busy.
//   Result channel: result_strobe marks each result for one cycle; the
//   receiver cannot stall, so results are simply presented in order.
//   Configuration: APB-style, keep_count at address 0, pready always high.
//   Reset (rst, synchronous): empties the store, keep_count = MAX_KEEP.
module top_k_largest_tracker_unit #(
  parameter int MAX_KEEP = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  tkt_pkg::tkt_data_t         value,
  // result channel
  output logic                       result_strobe,
  output tkt_pkg::tkt_data_t         held_value,
  output logic                       valid_res,
  output logic                       last,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkt_pkg::ADDR_W-1:0] paddr,
  input  logic [tkt_pkg::APB_W-1:0]  pwdata,
  output logic [tkt_pkg::APB_W-1:0]  prdata,
  output logic                       pready
);
  import tkt_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int KW    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic             state;
  logic [CNT_W-1:0] filled_count;
  logic [CNT_W-1:0] remaining;
  logic [KW-1:0]    keep_count;
  logic [KW-1:0]    k_eff;
  logic             full;
  logic             accept;
  logic             push_ok;
  logic             beats_min;
  logic             cfg_wr;
  tkt_ctl_t         ctl;

  tkt_data_t            entry [MAX_KEEP];
  logic [MAX_KEEP-1:0]  le;
  logic [MAX_KEEP-1:0]  in_use;
  logic [MAX_KEEP-1:0]  is_top;

  // ---------------------------------------------------------------
  // Configuration port: single register, zero wait states.
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  // Address bits below the word boundary all select keep_count.
  assign prdata = APB_W'(keep_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KW'(MAX_KEEP);
    end else if (cfg_wr) begin
      keep_count <= KW'(pwdata[KEEP_W-1:0]);
    end
  end

  // Clamp K into 1..MAX_KEEP.
  always_comb begin
    k_eff = keep_count;
    if (k_eff == '0) begin
      k_eff = KW'(1);
    end
    if (k_eff > KW'(MAX_KEEP)) begin
      k_eff = KW'(MAX_KEEP);
    end
  end

  assign full      = KW'(filled_count) >= k_eff;
  assign busy      = (state == ST_DUMP);
  assign accept    = start && !busy;
  // Full store: only a value strictly above the minimum gets in.
  assign beats_min = value > entry[0];
  assign push_ok   = accept && (operation == OP_PUSH) && (!full || beats_min);

  always_comb begin
    ctl.ins  = push_ok && !full;
    ctl.repl = push_ok && full;
    ctl.rot  = busy;
  end

  // ---------------------------------------------------------------
  // Chain of cells.
  // ---------------------------------------------------------------
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    tkt_data_t prev_e;
    tkt_data_t next_e;
    logic      le_dn;
    logic      le_up;

    assign in_use[i] = CNT_W'(i) < filled_count;
    assign is_top[i] = filled_count == CNT_W'(i + 1);

    if (i == 0) begin : g_bot
      assign prev_e = value;
      assign le_dn  = 1'b1;
    end else begin : g_mid
      assign prev_e = entry[i-1];
      assign le_dn  = le[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_top
      assign next_e = entry[0];
      assign le_up  = 1'b0;
    end else begin : g_low
      assign next_e = entry[i+1];
      assign le_up  = le[i+1];
    end

    tkt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_value  (value),
      .in_use     (in_use[i]),
      .is_top     (is_top[i]),
      .le_below   (le_dn),
      .le_above   (le_up),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .wrap_entry (entry[0]),
      .entry      (entry[i]),
      .le         (le[i])
    );
  end

  // ---------------------------------------------------------------
  // Fill count, dump sequencing and result register.
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      filled_count  <= '0;
      remaining     <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (ctl.ins) begin
        filled_count <= filled_count + CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (accept && operation == OP_DUMP) begin
            if (filled_count == '0) begin
              // Empty store: one marker item.
              result_strobe <= 1'b1;
            end else begin
              state     <= ST_DUMP;
              remaining <= filled_count;
            end
          end
        end
        ST_DUMP: begin
          result_strobe <= 1'b1;
          remaining     <= remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload of the result register.
  always_ff @(posedge clk) begin
    if (busy) begin
      held_value <= entry[0];
      valid_res  <= 1'b1;
      last       <= (remaining == CNT_W'(1));
    end else begin
      held_value <= '0;
      valid_res  <= 1'b0;
      last       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    filled_count <= CNT_W'(MAX_KEEP))
    else $error("fill count above depth");

  a_empty_last : assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !valid_res) |-> last)
    else $error("empty result not marked last");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PUSH && !full) |=>
      filled_count == $past(filled_count) + CNT_W'(1))
    else $error("insert did not grow the store");

  a_dump_nonempty : assert property (@(posedge clk) disable iff (rst)
    busy |-> (filled_count != '0 && remaining != '0))
    else $error("read-out running on empty store");
`endif

endmodule

/* src/tkt_cell.sv */
// One storage cell of the sorted chain: holds one entry and trades it
// with its neighbors. Depends on tkt_pkg.
module tkt_cell (
  input  logic              clk,
  input  tkt_pkg::tkt_ctl_t ctl,
  input  tkt_pkg::tkt_data_t new_value,
  input  logic              in_use,
  input  logic              is_top,
  input  logic              le_below,
  input  logic              le_above,
  input  tkt_pkg::tkt_data_t prev_entry,
  input  tkt_pkg::tkt_data_t next_entry,
  input  tkt_pkg::tkt_data_t wrap_entry,
  output tkt_pkg::tkt_data_t entry,
  output logic              le
);
  import tkt_pkg::*;

  tkt_data_t entry_next;

  // Entry is held and no greater than the offered value.
  assign le = in_use && (entry <= new_value);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (!le) begin
        entry_next = le_below ? new_value : prev_entry;
      end
    end else if (ctl.repl) begin
      if (le_above) begin
        entry_next = next_entry;
      end else if (le) begin
        entry_next = new_value;
      end
    end else if (ctl.rot) begin
      if (in_use) begin
        entry_next = is_top ? wrap_entry : next_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
